/* hw/rtl/lrmt_pkg.sv */
// ----------------------------------------------------------------------------
// lrmt_pkg
// Shared types, constants and helpers of the lazy range minimum tree.
// ----------------------------------------------------------------------------
package lrmt_pkg;

  localparam int LEAVES      = 1024;
  localparam int TREE_LEVELS = 10;
  localparam int TREE_SZ     = 1 << TREE_LEVELS;
  localparam int USABLE      = (LEAVES < TREE_SZ) ? LEAVES : TREE_SZ;

  localparam int KEY_W   = 20;
  localparam int PAIR_W  = 2 * KEY_W;
  localparam int POS_W   = 11;
  localparam int REQ_W   = 2;

  // node index 1 .. 2*TREE_SZ-1, range bounds can reach 2*TREE_SZ
  localparam int IDX_W     = TREE_LEVELS + 2;
  localparam int NODE_AW   = TREE_LEVELS + 1;
  localparam int TAG_AW    = TREE_LEVELS;
  localparam int NODE_DEPTH = 2 * TREE_SZ;
  localparam int TAG_DEPTH  = TREE_SZ;
  localparam int LVL_W     = $clog2(TREE_LEVELS + 2);

  localparam logic [KEY_W-1:0]  IDENT_KEY  = KEY_W'(100100);
  localparam logic [PAIR_W-1:0] IDENT_PAIR = {IDENT_KEY, IDENT_KEY};

  typedef enum logic [REQ_W-1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_RMQ   = 2'd2,
    REQ_CHMIN = 2'd3
  } req_t;

  typedef struct packed {
    logic                we;
    logic [NODE_AW-1:0]  wr_addr;
    logic [PAIR_W-1:0]   wdata;
    logic [NODE_AW-1:0]  rd_addr;
  } node_ctl_t;

  typedef struct packed {
    logic                we;
    logic [TAG_AW-1:0]   wr_addr;
    logic [PAIR_W-1:0]   wdata;
    logic [TAG_AW-1:0]   rd_addr;
  } tag_ctl_t;

  // pairs are {len, rank}, so plain unsigned order is the pair order
  function automatic logic [PAIR_W-1:0] pmin(input logic [PAIR_W-1:0] x,
                                             input logic [PAIR_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

endpackage

/* hw/rtl/lrmt_if.sv */
// ----------------------------------------------------------------------------
// lrmt_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface lrmt_in_if;
  logic                        valid;
  logic                        ready;
  logic [lrmt_pkg::REQ_W-1:0]  req_type;
  logic [lrmt_pkg::POS_W-1:0]  left;
  logic [lrmt_pkg::POS_W-1:0]  right;
  logic [lrmt_pkg::KEY_W-1:0]  val_len;
  logic [lrmt_pkg::KEY_W-1:0]  val_rank;

  modport source(output valid, req_type, left, right, val_len, val_rank, input ready);
  modport sink(input valid, req_type, left, right, val_len, val_rank, output ready);
endinterface

interface lrmt_out_if;
  logic                        valid;
  logic                        ready;
  logic [lrmt_pkg::KEY_W-1:0]  res_len;
  logic [lrmt_pkg::KEY_W-1:0]  res_rank;

  modport source(output valid, res_len, res_rank, input ready);
  modport sink(input valid, res_len, res_rank, output ready);
endinterface

/* hw/rtl/lrmt_ram.sv */
// ----------------------------------------------------------------------------
// lrmt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrmt_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

endmodule

/* hw/rtl/lrmt_seq.sv */
// ----------------------------------------------------------------------------
// lrmt_seq
// Request sequencer: push, give, pull and range walk over the two memories.
// ----------------------------------------------------------------------------
module lrmt_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  lrmt_in_if.sink                      in_chan,
  lrmt_out_if.source                   out_chan,
  output lrmt_pkg::node_ctl_t          node_ctl,
  input  logic [lrmt_pkg::PAIR_W-1:0]  node_rdata,
  output lrmt_pkg::tag_ctl_t           tag_ctl,
  input  logic [lrmt_pkg::PAIR_W-1:0]  tag_rdata
);

  localparam int IW = lrmt_pkg::IDX_W;
  localparam int PW = lrmt_pkg::PAIR_W;
  localparam int LW = lrmt_pkg::LVL_W;
  localparam int NA = lrmt_pkg::NODE_AW;
  localparam int TA = lrmt_pkg::TAG_AW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SETUP, S_PUSH_LVL, S_PUSH_TAG, S_PUSH_F, S_PUSH_CLR,
    S_GIVE_RD, S_GIVE_WR, S_SET_WR, S_GET_RD, S_GET_CAP,
    S_Q_LOOP, S_Q_CAPA, S_Q_CAPB, S_C_LOOP,
    S_PULL_LVL, S_PULL_R0, S_PULL_R1, S_PULL_WR, S_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  lrmt_pkg::req_t              req_r, req_nxt;
  logic [lrmt_pkg::POS_W-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [PW-1:0]               val_r, val_nxt;
  logic [IW-1:0]               a_r, a_nxt, b_r, b_nxt, a0_r, a0_nxt, b0_r, b0_nxt;
  logic [IW-1:0]               k_r, k_nxt, gk_r, gk_nxt;
  logic [LW-1:0]               lvl_r, lvl_nxt;
  logic                        side_r, side_nxt, ch_r, ch_nxt;
  logic                        pt_r, pt_nxt, ctx_push_r, ctx_push_nxt;
  logic [PW-1:0]               f_r, f_nxt, hold_r, hold_nxt, sl_r, sl_nxt, sr_r, sr_nxt;
  logic [PW-1:0]               res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [NA-1:0]               clr_r, clr_nxt;

  logic [IW-1:0] mask, push_k, pull_k;
  logic          push_cond, pull_cond;
  logic [31:0]   l32, r32, ls32, rs32;

  // level walk helpers, one node per side and level
  always_comb begin
    mask      = (IW'(1) << lvl_r) - IW'(1);
    push_cond = side_r ? (!pt_r && ((b_r & mask) != '0)) : (pt_r || ((a_r & mask) != '0));
    push_k    = side_r ? ((b_r - IW'(1)) >> lvl_r) : (a_r >> lvl_r);
    pull_cond = side_r ? (!pt_r && ((b0_r & mask) != '0)) : (pt_r || ((a0_r & mask) != '0));
    pull_k    = side_r ? ((b0_r - IW'(1)) >> lvl_r) : (a0_r >> lvl_r);
    l32       = 32'(l_r);
    r32       = 32'(r_r);
    ls32      = (l32 > 32'(lrmt_pkg::USABLE)) ? 32'(lrmt_pkg::USABLE) : l32;
    rs32      = (r32 > 32'(lrmt_pkg::USABLE)) ? 32'(lrmt_pkg::USABLE) : r32;
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    val_nxt      = val_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    a0_nxt       = a0_r;
    b0_nxt       = b0_r;
    k_nxt        = k_r;
    gk_nxt       = gk_r;
    lvl_nxt      = lvl_r;
    side_nxt     = side_r;
    ch_nxt       = ch_r;
    pt_nxt       = pt_r;
    ctx_push_nxt = ctx_push_r;
    f_nxt        = f_r;
    hold_nxt     = hold_r;
    sl_nxt       = sl_r;
    sr_nxt       = sr_r;
    res_nxt      = res_r;
    clr_nxt      = clr_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;

    node_ctl.we      = 1'b0;
    node_ctl.wr_addr = gk_r[NA-1:0];
    node_ctl.wdata   = lrmt_pkg::pmin(f_r, node_rdata);
    node_ctl.rd_addr = gk_r[NA-1:0];
    tag_ctl.we       = 1'b0;
    tag_ctl.wr_addr  = gk_r[TA-1:0];
    tag_ctl.wdata    = lrmt_pkg::pmin(f_r, tag_rdata);
    tag_ctl.rd_addr  = gk_r[TA-1:0];

    unique case (state_r)
      S_CLR: begin
        node_ctl.we      = 1'b1;
        node_ctl.wr_addr = clr_r;
        node_ctl.wdata   = lrmt_pkg::IDENT_PAIR;
        tag_ctl.we       = !clr_r[NA-1];
        tag_ctl.wr_addr  = clr_r[TA-1:0];
        tag_ctl.wdata    = lrmt_pkg::IDENT_PAIR;
        clr_nxt          = clr_r + NA'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          req_nxt   = lrmt_pkg::req_t'(in_chan.req_type);
          l_nxt     = in_chan.left;
          r_nxt     = in_chan.right;
          val_nxt   = {in_chan.val_len, in_chan.val_rank};
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        lvl_nxt  = LW'(lrmt_pkg::TREE_LEVELS);
        side_nxt = 1'b0;
        if (req_r == lrmt_pkg::REQ_SET || req_r == lrmt_pkg::REQ_GET) begin
          pt_nxt = 1'b1;
          a_nxt  = IW'(l32 + 32'(lrmt_pkg::TREE_SZ));
          a0_nxt = IW'(l32 + 32'(lrmt_pkg::TREE_SZ));
          if (l32 >= 32'(lrmt_pkg::USABLE)) begin
            sl_nxt    = lrmt_pkg::IDENT_PAIR;
            state_nxt = (req_r == lrmt_pkg::REQ_SET) ? S_IDLE : S_OUT;
          end else begin
            state_nxt = S_PUSH_LVL;
          end
        end else begin
          pt_nxt = 1'b0;
          a_nxt  = IW'(ls32 + 32'(lrmt_pkg::TREE_SZ));
          a0_nxt = IW'(ls32 + 32'(lrmt_pkg::TREE_SZ));
          b_nxt  = IW'(rs32 + 32'(lrmt_pkg::TREE_SZ));
          b0_nxt = IW'(rs32 + 32'(lrmt_pkg::TREE_SZ));
          if (ls32 >= rs32) begin
            sl_nxt    = lrmt_pkg::IDENT_PAIR;
            state_nxt = (req_r == lrmt_pkg::REQ_RMQ) ? S_OUT : S_IDLE;
          end else begin
            state_nxt = S_PUSH_LVL;
          end
        end
      end
      S_PUSH_LVL: begin
        if (lvl_r == '0) begin
          side_nxt = 1'b0;
          sl_nxt   = lrmt_pkg::IDENT_PAIR;
          sr_nxt   = lrmt_pkg::IDENT_PAIR;
          f_nxt    = val_r;
          case (req_r)
            lrmt_pkg::REQ_SET: state_nxt = S_SET_WR;
            lrmt_pkg::REQ_GET: state_nxt = S_GET_RD;
            lrmt_pkg::REQ_RMQ: state_nxt = S_Q_LOOP;
            default:           state_nxt = S_C_LOOP;
          endcase
        end else if (push_cond) begin
          k_nxt     = push_k;
          state_nxt = S_PUSH_TAG;
        end else begin
          side_nxt = !side_r;
          if (side_r) begin
            lvl_nxt = lvl_r - LW'(1);
          end
        end
      end
      S_PUSH_TAG: begin
        tag_ctl.rd_addr = k_r[TA-1:0];
        state_nxt       = S_PUSH_F;
      end
      S_PUSH_F: begin
        f_nxt        = tag_rdata;
        gk_nxt       = {1'b0, k_r[TA-1:0], 1'b0};
        ch_nxt       = 1'b0;
        ctx_push_nxt = 1'b1;
        state_nxt    = S_GIVE_RD;
      end
      S_GIVE_RD: begin
        state_nxt = S_GIVE_WR;
      end
      S_GIVE_WR: begin
        node_ctl.we = 1'b1;
        tag_ctl.we  = (gk_r < IW'(lrmt_pkg::TREE_SZ));
        if (ctx_push_r) begin
          if (!ch_r) begin
            ch_nxt    = 1'b1;
            gk_nxt    = gk_r | IW'(1);
            state_nxt = S_GIVE_RD;
          end else begin
            state_nxt = S_PUSH_CLR;
          end
        end else begin
          side_nxt  = !side_r;
          state_nxt = S_C_LOOP;
          if (side_r) begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
          end
        end
      end
      S_PUSH_CLR: begin
        tag_ctl.we      = 1'b1;
        tag_ctl.wr_addr = k_r[TA-1:0];
        tag_ctl.wdata   = lrmt_pkg::IDENT_PAIR;
        side_nxt        = !side_r;
        if (side_r) begin
          lvl_nxt = lvl_r - LW'(1);
        end
        state_nxt = S_PUSH_LVL;
      end
      S_SET_WR: begin
        node_ctl.we      = 1'b1;
        node_ctl.wr_addr = a_r[NA-1:0];
        node_ctl.wdata   = val_r;
        lvl_nxt          = LW'(1);
        side_nxt         = 1'b0;
        state_nxt        = S_PULL_LVL;
      end
      S_GET_RD: begin
        node_ctl.rd_addr = a_r[NA-1:0];
        state_nxt        = S_GET_CAP;
      end
      S_GET_CAP: begin
        sl_nxt    = node_rdata;
        state_nxt = S_OUT;
      end
      S_Q_LOOP: begin
        if (!side_r) begin
          node_ctl.rd_addr = a_r[NA-1:0];
          if (a_r >= b_r) begin
            sl_nxt    = lrmt_pkg::pmin(sl_r, sr_r);
            state_nxt = S_OUT;
          end else if (a_r[0]) begin
            state_nxt = S_Q_CAPA;
          end else begin
            side_nxt = 1'b1;
          end
        end else begin
          node_ctl.rd_addr = NA'(b_r - IW'(1));
          if (b_r[0]) begin
            b_nxt     = b_r - IW'(1);
            state_nxt = S_Q_CAPB;
          end else begin
            a_nxt    = a_r >> 1;
            b_nxt    = b_r >> 1;
            side_nxt = 1'b0;
          end
        end
      end
      S_Q_CAPA: begin
        sl_nxt    = lrmt_pkg::pmin(sl_r, node_rdata);
        a_nxt     = a_r + IW'(1);
        side_nxt  = 1'b1;
        state_nxt = S_Q_LOOP;
      end
      S_Q_CAPB: begin
        sr_nxt    = lrmt_pkg::pmin(node_rdata, sr_r);
        a_nxt     = a_r >> 1;
        b_nxt     = b_r >> 1;
        side_nxt  = 1'b0;
        state_nxt = S_Q_LOOP;
      end
      S_C_LOOP: begin
        ctx_push_nxt = 1'b0;
        if (!side_r) begin
          if (a_r >= b_r) begin
            lvl_nxt   = LW'(1);
            state_nxt = S_PULL_LVL;
          end else if (a_r[0]) begin
            gk_nxt    = a_r;
            a_nxt     = a_r + IW'(1);
            state_nxt = S_GIVE_RD;
          end else begin
            side_nxt = 1'b1;
          end
        end else begin
          if (b_r[0]) begin
            gk_nxt    = b_r - IW'(1);
            b_nxt     = b_r - IW'(1);
            state_nxt = S_GIVE_RD;
          end else begin
            a_nxt    = a_r >> 1;
            b_nxt    = b_r >> 1;
            side_nxt = 1'b0;
          end
        end
      end
      S_PULL_LVL: begin
        if (lvl_r > LW'(lrmt_pkg::TREE_LEVELS)) begin
          state_nxt = S_IDLE;
        end else if (pull_cond) begin
          k_nxt     = pull_k;
          state_nxt = S_PULL_R0;
        end else begin
          side_nxt = !side_r;
          if (side_r) begin
            lvl_nxt = lvl_r + LW'(1);
          end
        end
      end
      S_PULL_R0: begin
        node_ctl.rd_addr = {k_r[TA-1:0], 1'b0};
        state_nxt        = S_PULL_R1;
      end
      S_PULL_R1: begin
        node_ctl.rd_addr = {k_r[TA-1:0], 1'b1};
        hold_nxt         = node_rdata;
        state_nxt        = S_PULL_WR;
      end
      S_PULL_WR: begin
        node_ctl.we      = 1'b1;
        node_ctl.wr_addr = k_r[NA-1:0];
        node_ctl.wdata   = lrmt_pkg::pmin(hold_r, node_rdata);
        side_nxt         = !side_r;
        if (side_r) begin
          lvl_nxt = lvl_r + LW'(1);
        end
        state_nxt = S_PULL_LVL;
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          res_nxt       = sl_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    val_r      <= val_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    a0_r       <= a0_nxt;
    b0_r       <= b0_nxt;
    k_r        <= k_nxt;
    gk_r       <= gk_nxt;
    lvl_r      <= lvl_nxt;
    side_r     <= side_nxt;
    ch_r       <= ch_nxt;
    pt_r       <= pt_nxt;
    ctx_push_r <= ctx_push_nxt;
    f_r        <= f_nxt;
    hold_r     <= hold_nxt;
    sl_r       <= sl_nxt;
    sr_r       <= sr_nxt;
    res_r      <= res_nxt;
  end

  assign in_chan.ready     = (state_r == S_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.res_len  = res_r[PW-1:lrmt_pkg::KEY_W];
  assign out_chan.res_rank = res_r[lrmt_pkg::KEY_W-1:0];

endmodule

/* hw/rtl/lazy_range_min_tree.sv */
// ----------------------------------------------------------------------------
// lazy_range_min_tree
// Lazy segment tree with point set and get, range chmin and range minimum over (len, rank) pairs.
// ----------------------------------------------------------------------------
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        req_type, left, right, val_len, val_rank
//   out_chan  out  valid/ready        res_len, res_rank
//
// per request: take-in and setup, level checks from the root down with a tag push where
// needed, then a range walk per side and level with node reads or node gives, or a point
// access; set and chmin then pull the levels back up, get and range min load a result
// each memory has one read port, so its reads are done one at a time
// after reset a clearing pass writes the identity to all 2*TREE_SZ nodes and TREE_SZ tags
// a waiting result lets the next request in; a second result stalls until it transfers
module lazy_range_min_tree (
  input  logic         clk,
  input  logic         rst_n,
  lrmt_in_if.sink      in_chan,
  lrmt_out_if.source   out_chan
);

  lrmt_pkg::node_ctl_t               node_ctl;
  lrmt_pkg::tag_ctl_t                tag_ctl;
  logic [lrmt_pkg::PAIR_W-1:0]       node_rdata;
  logic [lrmt_pkg::PAIR_W-1:0]       tag_rdata;

  lrmt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .node_ctl   (node_ctl),
    .node_rdata (node_rdata),
    .tag_ctl    (tag_ctl),
    .tag_rdata  (tag_rdata)
  );

  lrmt_ram #(
    .DEPTH (lrmt_pkg::NODE_DEPTH),
    .WIDTH (lrmt_pkg::PAIR_W)
  ) u_node_ram (
    .clk     (clk),
    .we      (node_ctl.we),
    .wr_addr (node_ctl.wr_addr),
    .wdata   (node_ctl.wdata),
    .rd_addr (node_ctl.rd_addr),
    .rdata   (node_rdata)
  );

  lrmt_ram #(
    .DEPTH (lrmt_pkg::TAG_DEPTH),
    .WIDTH (lrmt_pkg::PAIR_W)
  ) u_tag_ram (
    .clk     (clk),
    .we      (tag_ctl.we),
    .wr_addr (tag_ctl.wr_addr),
    .wdata   (tag_ctl.wdata),
    .rd_addr (tag_ctl.rd_addr),
    .rdata   (tag_rdata)
  );

  // no tree update while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !node_ctl.we && !tag_ctl.we)
    else $error("memory written while idle");

  // a transfer in starts work, so the next cycle is busy
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while busy");

  // tags never rise above the identity
  a_tag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tag_ctl.we |-> tag_ctl.wdata <= lrmt_pkg::IDENT_PAIR)
    else $error("tag above identity");

endmodule
